@@ src/pickup_delivery_route_search_defines.svh @@
// Assertion macros shared by the route search RTL.
// Depends on nothing; each user must have clk and rst in scope.
`ifndef PICKUP_DELIVERY_ROUTE_SEARCH_DEFINES_SVH
`define PICKUP_DELIVERY_ROUTE_SEARCH_DEFINES_SVH

// Checked property, ignored while reset is high.
`define PDRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds through reset.
`define PDRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pdrs_pkg.sv @@
// Shared constants and types for the pickup/delivery route search block.
// Depends on nothing; used by every module of the block but pdrs_ram.
`default_nettype none
package pdrs_pkg;

  localparam int PT_W        = 5;
  localparam int COST_W      = 16;
  localparam int DIST_W      = 21;
  localparam int ACC_W       = 22;
  localparam int MIN_W       = 20;
  localparam int PROD_W      = MIN_W + PT_W;
  localparam int NPASS_W     = 4;
  localparam int ADDR_W      = 2 * PT_W;
  localparam int TABLE_DEPTH = 1 << ADDR_W;
  localparam int STACK_DEPTH = 1 << PT_W;

  localparam logic [NPASS_W-1:0] MAX_PASSENGERS = 4'd15;
  localparam logic [NPASS_W-1:0] RESET_NPASS    = 4'd1;
  localparam logic [MIN_W-1:0]   NO_MIN_COST    = 20'd1000000;
  localparam logic [DIST_W-1:0]  RESET_BOUND    = 21'd100000;

  // Configuration register indexes.
  localparam logic CFG_NUM_PASSENGERS = 1'b0;
  localparam logic CFG_INITIAL_BOUND  = 1'b1;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_SCAN,
    OP_NEXT_CAND,
    OP_READ_EDGE,
    OP_TAKE,
    OP_RET_UNDO,
    OP_MUL,
    OP_PUSH,
    OP_UNDO_NEXT,
    OP_POP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_zero;
    logic pt_over;
    logic fast_ok;
    logic edge_zero;
    logic at_last;
    logic depth_one;
    logic bound_ok;
  } dp_status_t;

endpackage
`default_nettype wire

@@ src/pdrs_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module pdrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first port, registered read on the second.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/pdrs_datapath.sv @@
// Datapath of the route search: cost table, search stacks, distances, bound.
// Depends on pdrs_pkg and pdrs_ram; driven by pdrs_ctrl operations.
`default_nettype none
`include "pickup_delivery_route_search_defines.svh"
module pdrs_datapath import pdrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic               load_we,
  input  wire logic [PT_W-1:0]    load_row,
  input  wire logic [PT_W-1:0]    load_col,
  input  wire logic [COST_W-1:0]  load_cost,
  input  wire logic [NPASS_W-1:0] num_passengers,
  input  wire logic [DIST_W-1:0]  initial_bound,
  output logic      [DIST_W-1:0]  best_distance,
  output logic                    route_found
);

  logic [NPASS_W-1:0]  n_reg;
  logic [PT_W-1:0]     last_pt;
  logic [PT_W-1:0]     scan_i;
  logic [PT_W-1:0]     scan_j;
  logic                scan_vld;
  logic [MIN_W-1:0]    min_cost;
  logic [DIST_W-1:0]   best;
  logic [ACC_W-1:0]    cur_dist;
  logic [PT_W-1:0]     pos;
  logic                onboard;
  logic [STACK_DEPTH-1:0] visited;
  logic [PT_W-1:0]     depth;
  logic [PROD_W-1:0]   prod;
  logic [PT_W-1:0]     cand_stk      [STACK_DEPTH];
  logic [PT_W-1:0]     prev_pos_stk  [STACK_DEPTH];
  logic [ACC_W-1:0]    prev_dist_stk [STACK_DEPTH];

  logic [NPASS_W-1:0]  n_eff;
  logic [PT_W-1:0]     pt;
  logic [PT_W-1:0]     pt_pair;
  logic [PT_W-1:0]     legs_left;
  logic [ADDR_W-1:0]   rd_addr;
  logic [COST_W-1:0]   rdata;
  logic [ACC_W-1:0]    total;
  logic [PROD_W:0]     bound_sum;

  // Candidate at the current depth and its matching pickup.
  assign pt        = cand_stk[depth];
  assign pt_pair   = pt - PT_W'(n_reg);
  assign legs_left = last_pt - depth;
  assign n_eff     = (num_passengers > MAX_PASSENGERS) ? MAX_PASSENGERS : num_passengers;
  assign total     = cur_dist + ACC_W'(rdata);
  assign bound_sum = (PROD_W+1)'(cur_dist) + (PROD_W+1)'(prod);

  // Cost table read address follows the current operation.
  always_comb begin
    case (cmd.op)
      OP_SCAN:      rd_addr = {scan_i, scan_j};
      OP_READ_EDGE: rd_addr = {pos, pt};
      default:      rd_addr = {pt, PT_W'(0)};
    endcase
  end

  pdrs_ram #(.WIDTH(COST_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr ({load_row, load_col}),
    .wdata (load_cost),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Status back to the controller.
  always_comb begin
    status.scan_done = (scan_i == last_pt) && (scan_j == last_pt);
    status.last_zero = (last_pt == '0);
    status.pt_over   = (pt > last_pt);
    status.fast_ok   = !(onboard && (pt <= PT_W'(n_reg))) &&
                       !((pt > PT_W'(n_reg)) && !visited[pt_pair]) &&
                       !visited[pt];
    status.edge_zero = (rdata == '0);
    status.at_last   = (depth == last_pt);
    status.depth_one = (depth == PT_W'(1));
    status.bound_ok  = (bound_sum < (PROD_W+1)'(best));
  end

  // Control and search state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_vld <= 1'b0;
      visited  <= '0;
      onboard  <= 1'b0;
      depth    <= '0;
      cur_dist <= '0;
      pos      <= '0;
      min_cost <= NO_MIN_COST;
      best     <= RESET_BOUND;
      n_reg    <= RESET_NPASS;
      last_pt  <= '0;
      scan_i   <= '0;
      scan_j   <= '0;
    end else begin
      scan_vld <= (cmd.op == OP_SCAN);
      if (scan_vld && (rdata != '0) && (MIN_W'(rdata) < min_cost)) begin
        min_cost <= MIN_W'(rdata);
      end
      case (cmd.op)
        OP_INIT: begin
          n_reg    <= n_eff;
          last_pt  <= {n_eff, 1'b0};
          scan_i   <= '0;
          scan_j   <= '0;
          min_cost <= NO_MIN_COST;
          best     <= initial_bound;
          visited  <= '0;
          onboard  <= 1'b0;
          cur_dist <= '0;
          pos      <= '0;
          depth    <= PT_W'(1);
        end
        OP_SCAN: begin
          if (scan_j == last_pt) begin
            scan_j <= '0;
            scan_i <= scan_i + PT_W'(1);
          end else begin
            scan_j <= scan_j + PT_W'(1);
          end
        end
        OP_TAKE: begin
          visited[pt] <= 1'b1;
          cur_dist    <= cur_dist + ACC_W'(rdata);
          onboard     <= (pt <= PT_W'(n_reg));
          pos         <= pt;
        end
        OP_RET_UNDO, OP_UNDO_NEXT: begin
          if (cmd.op == OP_RET_UNDO && total < ACC_W'(best)) begin
            best <= DIST_W'(total);
          end
          visited[pt] <= 1'b0;
          cur_dist    <= prev_dist_stk[depth];
          pos         <= prev_pos_stk[depth];
          onboard     <= (pt > PT_W'(n_reg));
        end
        OP_PUSH: depth <= depth + PT_W'(1);
        OP_POP:  depth <= depth - PT_W'(1);
        default: ;
      endcase
    end
  end

  // Stacks and product hold payload only.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INIT: cand_stk[1] <= PT_W'(1);
      OP_NEXT_CAND, OP_RET_UNDO, OP_UNDO_NEXT: cand_stk[depth] <= pt + PT_W'(1);
      OP_TAKE: begin
        prev_pos_stk[depth]  <= pos;
        prev_dist_stk[depth] <= cur_dist;
      end
      OP_MUL:  prod <= PROD_W'(min_cost) * PROD_W'(legs_left);
      OP_PUSH: cand_stk[depth + PT_W'(1)] <= PT_W'(1);
      default: ;
    endcase
  end

  assign best_distance = best;
  assign route_found   = (best < initial_bound);

  `PDRS_ASSERT(a_push_below_last, (cmd.op == OP_PUSH) |-> (depth < last_pt), "push past last point")
  `PDRS_ASSERT(a_take_adds_cost, (cmd.op == OP_TAKE) |=> (cur_dist > $past(cur_dist)), "take did not add cost")
  `PDRS_ASSERT(a_pop_nonzero, (cmd.op == OP_POP) |-> (depth != '0), "pop at empty stack")

endmodule
`default_nettype wire

@@ src/pdrs_ctrl.sv @@
// Controller state machine of the route search: sequences scan and search.
// Depends on pdrs_pkg; drives pdrs_datapath through dp_cmd_t.
`default_nettype none
`include "pickup_delivery_route_search_defines.svh"
module pdrs_ctrl import pdrs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       run_go,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            done
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCAN  = 10'b00_0000_0010,
    S_DRAIN = 10'b00_0000_0100,
    S_CHECK = 10'b00_0000_1000,
    S_EDGE  = 10'b00_0001_0000,
    S_RET   = 10'b00_0010_0000,
    S_MUL   = 10'b00_0100_0000,
    S_CMP   = 10'b00_1000_0000,
    S_POP   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (run_go) begin
          cmd.op     = OP_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_done) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = status.last_zero ? S_DONE : S_CHECK;
      S_CHECK: begin
        if (status.pt_over) begin
          cmd.op     = OP_POP;
          state_next = status.depth_one ? S_DONE : S_POP;
        end else if (!status.fast_ok) begin
          cmd.op = OP_NEXT_CAND;
        end else begin
          cmd.op     = OP_READ_EDGE;
          state_next = S_EDGE;
        end
      end
      S_EDGE: begin
        if (status.edge_zero) begin
          cmd.op     = OP_NEXT_CAND;
          state_next = S_CHECK;
        end else begin
          cmd.op     = OP_TAKE;
          state_next = status.at_last ? S_RET : S_MUL;
        end
      end
      S_RET: begin
        cmd.op     = OP_RET_UNDO;
        state_next = S_CHECK;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.op     = status.bound_ok ? OP_PUSH : OP_UNDO_NEXT;
        state_next = S_CHECK;
      end
      S_POP: begin
        cmd.op     = OP_UNDO_NEXT;
        state_next = S_CHECK;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  `PDRS_ASSERT(a_run_sets_busy, (run_go && !busy) |=> busy, "run did not start")
  `PDRS_ASSERT(a_done_then_idle, done |=> !busy, "done not followed by idle")
  `PDRS_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy, "not idle after reset")

endmodule
`default_nettype wire

@@ src/pickup_delivery_route_search.sv @@
// Top level of the single-seat pickup/delivery route search.
// Depends on pdrs_pkg, pdrs_ctrl, pdrs_datapath (which holds pdrs_ram).
//
// A load transaction (command 0) writes one cost table entry; busy stays
// low, so loads stream one per cycle. A run transaction (command 1) raises
// busy, first scans the (2n+1)^2 used entries for the smallest nonzero
// cost, then walks the search tree: each candidate test has its own state,
// each edge lookup another, and each taken point adds the bound multiply
// and compare states, or the return edge check at the last depth;
// backtracking takes a pop and an undo step. The single read port of the
// cost table sets this sequence. The result appears for exactly one cycle
// with done high and must be captured then; the receiver cannot stall it.
// Configuration writes are always ready and are meant to be made
// while busy is low.
`default_nettype none
module pickup_delivery_route_search import pdrs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               command,
  input  wire logic [PT_W-1:0]    row,
  input  wire logic [PT_W-1:0]    col,
  input  wire logic [COST_W-1:0]  cost,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [DIST_W-1:0]  cfg_data,
  output logic                    done,
  output logic      [DIST_W-1:0]  best_distance,
  output logic                    route_found
);

  logic [NPASS_W-1:0] num_passengers;
  logic [DIST_W-1:0]  initial_bound;
  logic               accept;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_passengers <= RESET_NPASS;
      initial_bound  <= RESET_BOUND;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_PASSENGERS: num_passengers <= cfg_data[NPASS_W-1:0];
        CFG_INITIAL_BOUND:  initial_bound  <= cfg_data;
        default: ;
      endcase
    end
  end

  pdrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .run_go (accept && (command == CMD_RUN)),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  pdrs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .load_we        (accept && (command == CMD_LOAD)),
    .load_row       (row),
    .load_col       (col),
    .load_cost      (cost),
    .num_passengers (num_passengers),
    .initial_bound  (initial_bound),
    .best_distance  (best_distance),
    .route_found    (route_found)
  );

endmodule
`default_nettype wire

@@ dv/pickup_delivery_route_search_test.sv @@
// Self-checking testbench for the single-seat pickup/delivery route search.
// Depends on pdrs_pkg and the pickup_delivery_route_search RTL; it predicts
// every run result in SystemVerilog and compares it with the block's output.
`default_nettype none
module pickup_delivery_route_search_test;
  import pdrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum int {ST_LOAD, ST_RUN, ST_CFG, ST_DRAIN, ST_MODE} stim_kind_t;

  typedef struct {
    stim_kind_t        kind;
    logic              command;
    logic [PT_W-1:0]   row;
    logic [PT_W-1:0]   col;
    logic [COST_W-1:0] cost;
    logic              cfg_index;
    logic [DIST_W-1:0] cfg_data;
    int                idle_pct;
  } stim_t;

  typedef struct {
    logic [DIST_W-1:0] route_dist;
    logic              found;
  } route_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic command = 1'b0;
  logic [PT_W-1:0] row = '0;
  logic [PT_W-1:0] col = '0;
  logic [COST_W-1:0] cost = '0;
  logic cfg_valid = 1'b0;
  logic cfg_index = 1'b0;
  logic [DIST_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, route_found;
  logic [DIST_W-1:0] best_distance;

  pickup_delivery_route_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .row(row), .col(col), .cost(cost), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .best_distance(best_distance), .route_found(route_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stim_t         pending_items[$];
  route_result_t expected_routes[$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            idle_cycles = 0;
  int            idle_pct = 0;
  int            item_count = 0;
  bit            item_taken = 1'b0;
  bit            cfg_taken = 1'b0;

  // Predictor state: cost table, registers and search scratch.
  logic [COST_W-1:0] route_costs[TABLE_DEPTH];
  int unsigned pass_count = 1;
  int unsigned start_bound = 100000;
  int unsigned seen_mask, carrying, walk_dist;
  int unsigned walk_pts[STACK_DEPTH];

  function automatic int unsigned leg(int unsigned from, int unsigned to);
    return route_costs[(from & 31) * 32 + (to & 31)];
  endfunction

  function automatic bit can_enter(int unsigned depth, int unsigned pt, int unsigned n);
    if (carrying != 0 && pt <= n) return 1'b0;
    if (pt > n && !((seen_mask >> ((pt - n) & 31)) & 1)) return 1'b0;
    if (leg(walk_pts[(depth - 1) & 31], pt) == 0) return 1'b0;
    if ((seen_mask >> (pt & 31)) & 1) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void enter_point(int unsigned depth, int unsigned pt, int unsigned n);
    walk_pts[depth & 31] = pt;
    seen_mask |= 32'd1 << (pt & 31);
    walk_dist += leg(walk_pts[(depth - 1) & 31], pt);
    carrying = (pt <= n) ? 1 : 0;
  endfunction

  function automatic void leave_point(int unsigned depth, int unsigned n);
    int unsigned pt;
    pt = walk_pts[depth & 31];
    seen_mask &= ~(32'd1 << (pt & 31));
    walk_dist -= leg(walk_pts[(depth - 1) & 31], pt);
    carrying = (pt > n) ? 1 : 0;
  endfunction

  // Depth-first branch-and-bound over single-seat routes.
  function automatic route_result_t best_route();
    int unsigned n, last, depth, pt, c, cheapest, best, total;
    int unsigned cand[STACK_DEPTH];
    route_result_t r;
    n = (pass_count > 15) ? 15 : pass_count;
    last = 2 * n;
    seen_mask = 0;
    walk_dist = 0;
    carrying = 0;
    best = start_bound;
    for (int k = 0; k < STACK_DEPTH; k++) begin
      walk_pts[k] = 0;
      cand[k] = 0;
    end
    cheapest = 1000000;
    for (int unsigned i = 0; i <= last; i++)
      for (int unsigned j = 0; j <= last; j++) begin
        c = leg(i, j);
        if (c != 0 && c < cheapest) cheapest = c;
      end
    if (last != 0) begin
      depth = 1;
      cand[1] = 1;
      while (depth >= 1) begin
        pt = cand[depth & 31];
        if (pt > last) begin
          depth = depth - 1;
          if (depth == 0) break;
          leave_point(depth, n);
          cand[depth & 31]++;
        end else if (!can_enter(depth, pt, n)) begin
          cand[depth & 31]++;
        end else begin
          enter_point(depth, pt, n);
          if (depth == last) begin
            total = walk_dist + leg(pt, 0);
            if (total < best) best = total;
            leave_point(depth, n);
            cand[depth & 31]++;
          end else if (longint'(walk_dist) + longint'(cheapest) * longint'(last - depth)
                       < longint'(best)) begin
            depth = depth + 1;
            cand[depth & 31] = 1;
          end else begin
            leave_point(depth, n);
            cand[depth & 31]++;
          end
        end
      end
    end
    r.route_dist = best[DIST_W-1:0];
    r.found = (best < start_bound);
    return r;
  endfunction

  // Monitor: accepted transactions, predictions, result checks, watchdog.
  always @(posedge clk) begin
    route_result_t exp_r;
    bit progress;
    progress = 1'b0;
    item_taken = 1'b0;
    cfg_taken = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1'b1;
        progress = 1'b1;
        if (cfg_index == CFG_NUM_PASSENGERS) pass_count = cfg_data[NPASS_W-1:0];
        else start_bound = cfg_data;
      end
      if (start && !busy) begin
        item_taken = 1'b1;
        progress = 1'b1;
        if (command == CMD_LOAD) route_costs[row * 32 + col] = cost;
        else expected_routes.push_back(best_route());
      end
      if (done) begin
        progress = 1'b1;
        if (expected_routes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: best_distance %0d route_found %0b",
                     best_distance, route_found);
        end else begin
          exp_r = expected_routes.pop_front();
          if (best_distance !== exp_r.route_dist || route_found !== exp_r.found) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                       exp_r.route_dist, exp_r.found, best_distance, route_found);
          end
        end
      end
      quiet_cycles = (busy || expected_routes.size() != 0 || start) ? 0 : quiet_cycles + 1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("pickup_delivery_route_search_test failed");
        $finish;
      end
    end
  end

  // Driver: presents queued transactions at the falling edge.
  always @(negedge clk) begin
    logic n_start, n_cfg_valid;
    stim_t s;
    n_start = start;
    n_cfg_valid = cfg_valid;
    if (!rst && !(start && !item_taken) && !(cfg_valid && !cfg_taken)) begin
      n_start = 1'b0;
      n_cfg_valid = 1'b0;
      if (pending_items.size() != 0) begin
        s = pending_items[0];
        case (s.kind)
          ST_MODE: begin
            idle_pct = s.idle_pct;
            void'(pending_items.pop_front());
          end
          ST_DRAIN: begin
            if (quiet_cycles >= SETTLE_CYCLES) void'(pending_items.pop_front());
          end
          ST_CFG: begin
            if (quiet_cycles >= SETTLE_CYCLES) begin
              n_cfg_valid = 1'b1;
              cfg_index <= s.cfg_index;
              cfg_data <= s.cfg_data;
              void'(pending_items.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= idle_pct) begin
              n_start = 1'b1;
              command <= s.command;
              row <= s.row;
              col <= s.col;
              cost <= s.cost;
              void'(pending_items.pop_front());
            end
          end
        endcase
      end
    end
    start <= n_start;
    cfg_valid <= n_cfg_valid;
  end

  // Stimulus builders.
  task automatic add_item(stim_kind_t k, logic cmd, int r, int c, int v);
    stim_t s;
    s = '{kind: k, command: cmd, row: PT_W'(r), col: PT_W'(c), cost: COST_W'(v),
          cfg_index: 1'b0, cfg_data: '0, idle_pct: 0};
    pending_items.push_back(s);
    if (k == ST_LOAD || k == ST_RUN) item_count++;
  endtask

  task automatic add_load(int r, int c, int v);
    add_item(ST_LOAD, CMD_LOAD, r, c, v);
  endtask

  task automatic add_run();
    add_item(ST_RUN, CMD_RUN, $urandom_range(31), $urandom_range(31), $urandom_range(65535));
  endtask

  task automatic add_cfg(logic idx, int unsigned v);
    stim_t s;
    s = '{kind: ST_CFG, command: 1'b0, row: '0, col: '0, cost: '0, cfg_index: idx,
          cfg_data: DIST_W'(v), idle_pct: 0};
    pending_items.push_back(s);
  endtask

  task automatic add_mode(int pct);
    stim_t s;
    s = '{kind: ST_MODE, command: 1'b0, row: '0, col: '0, cost: '0, cfg_index: 1'b0,
          cfg_data: '0, idle_pct: pct};
    pending_items.push_back(s);
  endtask

  function automatic int rand_cost();
    int p;
    p = $urandom_range(99);
    if (p < 20) return 0;
    if (p < 25) return 65535;
    if (p < 30) return $urandom_range(65535);
    return $urandom_range(1, 30);
  endfunction

  // Fills the used square for n points: random dense, all zero, or one chain.
  task automatic fill_table(int n, int style);
    for (int i = 0; i <= 2 * n; i++)
      for (int j = 0; j <= 2 * n; j++)
        add_load(i, j, (style == 0) ? rand_cost() : 0);
    if (style == 2) begin
      for (int p = 1; p <= n; p++) begin
        add_load((p == 1) ? 0 : p - 1 + n, p, $urandom_range(1, 1000));
        add_load(p, p + n, $urandom_range(1, 1000));
      end
      add_load(2 * n, 0, $urandom_range(1, 1000));
    end
  endtask

  initial begin
    int pct[4];
    int n, phase;
    pct = '{0, 66, 0, 13};

    // Directed part: smallest problem, extreme costs and bounds.
    add_cfg(CFG_NUM_PASSENGERS, 1);
    add_cfg(CFG_INITIAL_BOUND, 100000);
    add_load(0, 1, 65535); add_load(1, 2, 65535); add_load(2, 0, 65535);
    add_load(0, 0, 0); add_load(0, 2, 7); add_load(1, 0, 3);
    add_load(1, 1, 0); add_load(2, 1, 1); add_load(2, 2, 0);
    add_run();
    add_cfg(CFG_INITIAL_BOUND, 2097151);
    add_run();
    add_load(2, 0, 0);  // route whose return edge is missing
    add_run();
    add_cfg(CFG_INITIAL_BOUND, 0);
    add_run();
    add_cfg(CFG_NUM_PASSENGERS, 0);
    add_cfg(CFG_INITIAL_BOUND, 2097151);
    add_run();
    add_cfg(CFG_NUM_PASSENGERS, 1);
    fill_table(1, 1);  // no nonzero cost anywhere
    add_run();
    add_load(31, 31, 65535);  // outside the used points
    add_load(16, 15, 1);

    // Random phases with varied sizes, bounds and idling; the full-size
    // chain test at the end adds close to a thousand loads on its own.
    phase = 0;
    while (phase < 4 || item_count < 100) begin
      add_item(ST_DRAIN, 1'b0, 0, 0, 0);
      add_mode(pct[phase % 4]);
      n = ($urandom_range(9) == 0) ? 5 : $urandom_range(0, 4);
      add_cfg(CFG_NUM_PASSENGERS, n);
      case ($urandom_range(3))
        0: add_cfg(CFG_INITIAL_BOUND, 2097151);
        1: add_cfg(CFG_INITIAL_BOUND, 100000);
        2: add_cfg(CFG_INITIAL_BOUND, $urandom_range(0, 200));
        default: add_cfg(CFG_INITIAL_BOUND, $urandom_range(2097151));
      endcase
      fill_table(n, ($urandom_range(7) == 0) ? 2 : 0);
      repeat ($urandom_range(3, 10)) begin
        case ($urandom_range(9))
          0, 1, 2, 3: add_run();
          4, 5, 6: add_load($urandom_range(2 * n), $urandom_range(2 * n), rand_cost());
          7: add_load($urandom_range(31), $urandom_range(31), $urandom_range(65535));
          8: add_item(ST_DRAIN, 1'b0, 0, 0, 0);
          default: begin
            add_run();
            add_run();
          end
        endcase
      end
      add_run();
      phase++;
    end

    // Largest size: the maximum number of passengers, with a single chain route.
    add_mode(13);
    add_cfg(CFG_NUM_PASSENGERS, 15);
    add_cfg(CFG_INITIAL_BOUND, 2097151);
    fill_table(15, 2);
    add_run();
    add_load(30, 0, 0);
    add_run();

    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    wait (pending_items.size() == 0 && !start && !cfg_valid &&
          expected_routes.size() == 0);
    repeat (SETTLE_CYCLES + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_routes.size() == 0) begin
      $display("pickup_delivery_route_search_test passed");
    end else begin
      $display("pickup_delivery_route_search_test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+src
src/pdrs_pkg.sv
src/pdrs_ram.sv
src/pdrs_datapath.sv
src/pdrs_ctrl.sv
src/pickup_delivery_route_search.sv
dv/pickup_delivery_route_search_test.sv
